[src/assert_macros.svh]
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, reset included.
`define PWMF_ASSERT(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

// Checked only outside reset.
`define PWMF_ASSERT_RST(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

`endif

[src/pwmf_pkg.sv]
// Types and constants of the peer wire message framer.
`default_nettype none

package pwmf_pkg;

  typedef enum logic [3:0] {
    CMD_KEEPALIVE      = 4'd0,
    CMD_CHOKE          = 4'd1,
    CMD_UNCHOKE        = 4'd2,
    CMD_INTERESTED     = 4'd3,
    CMD_NOT_INTERESTED = 4'd4,
    CMD_HAVE           = 4'd5,
    CMD_BITFIELD       = 4'd6,
    CMD_REQUEST        = 4'd7,
    CMD_PIECE          = 4'd8,
    CMD_CANCEL         = 4'd9,
    CMD_PORT           = 4'd10,
    CMD_MARK           = 4'd11
  } cmd_t;

  // message IDs on the wire
  localparam logic [7:0] ID_CHOKE          = 8'd0;
  localparam logic [7:0] ID_UNCHOKE        = 8'd1;
  localparam logic [7:0] ID_INTERESTED     = 8'd2;
  localparam logic [7:0] ID_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] ID_HAVE           = 8'd4;
  localparam logic [7:0] ID_BITFIELD       = 8'd5;
  localparam logic [7:0] ID_REQUEST        = 8'd6;
  localparam logic [7:0] ID_PIECE          = 8'd7;
  localparam logic [7:0] ID_CANCEL         = 8'd8;
  localparam logic [7:0] ID_PORT           = 8'd9;

  // length prefix values
  localparam logic [31:0] LEN_KEEPALIVE  = 32'd0;
  localparam logic [31:0] LEN_STATUS     = 32'd1;
  localparam logic [31:0] LEN_HAVE       = 32'd5;
  localparam logic [31:0] LEN_REQUEST    = 32'd13;
  localparam logic [31:0] LEN_PIECE_BASE = 32'd9;
  localparam logic [31:0] LEN_PORT       = 32'd3;

  // header shift register: prefix, ID, three words
  localparam int MsgBytes = 17;
  localparam int MsgW     = 8 * MsgBytes;
  localparam int CntW     = 5;

  // total bytes per message kind (bitfield: header only)
  localparam logic [CntW-1:0] NB_KEEPALIVE = 5'd4;
  localparam logic [CntW-1:0] NB_STATUS    = 5'd5;
  localparam logic [CntW-1:0] NB_HAVE      = 5'd9;
  localparam logic [CntW-1:0] NB_REQUEST   = 5'd17;
  localparam logic [CntW-1:0] NB_PIECE     = 5'd13;
  localparam logic [CntW-1:0] NB_PORT      = 5'd7;
  localparam logic [CntW-1:0] NB_BF_HEAD   = 5'd5;

  // bitmap rows of 8 pieces; wide enough for the largest bitmap supported
  localparam int RowW = 6;

  localparam logic [8:0] PiecesReset = 9'd256;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  typedef enum logic [1:0] {
    JOB_MSG,
    JOB_BITFIELD,
    JOB_MARK
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [MsgW-1:0]   msg;
    logic [CntW-1:0]   nbytes;
    logic [RowW-1:0]   row;
    logic [2:0]        bit_sel;
    logic [RowW-1:0]   nrows;
    logic [7:0]        last_mask;
  } job_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_MAP_RD,
    BK_MAP_PUT,
    BK_MARK_RD,
    BK_MARK_WR
  } back_state_t;

endpackage

`default_nettype wire

[src/pwmf_ifs.sv]
// Command and byte stream channel interfaces.
`default_nettype none

interface pwmf_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [31:0] piece_index;
  logic [31:0] block_begin;
  logic [31:0] block_length;
  logic [15:0] listen_port;

  modport source (output valid, command, piece_index, block_begin, block_length,
                  listen_port, input ready);
  modport sink (input valid, command, piece_index, block_begin, block_length,
                listen_port, output ready);
endinterface

interface pwmf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

[src/peer_wire_message_framer_unit.sv]
// Peer wire message framer top level: front end, job queue, serializer.
// A command beat is pushed into the job queue; the back end pops it when idle.
// Throughput: one byte per cycle while tx.ready holds, plus an idle state per
// message in which the job is popped; a bitfield reads the bitmap RAM before
// each row it sends, and a mark reads its row and then writes it back.
// Reset: bitmap row valid bits clear, pieces_in_use returns to 256.
`default_nettype none
`include "assert_macros.svh"

module peer_wire_message_framer_unit #(
  parameter int MAX_PIECES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  pwmf_cmd_if.sink        cmd,
  pwmf_byte_if.source     tx,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data
);

  logic [8:0]        pieces_in_use;
  logic              push;
  logic              pop;
  pwmf_pkg::job_t    job_in;
  pwmf_pkg::job_t    job_out;
  pwmf_pkg::q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pieces_in_use <= pwmf_pkg::PiecesReset;
    end else if (cfg_we) begin
      pieces_in_use <= cfg_data;
    end
  end

  pwmf_front #(
    .MAX_PIECES (MAX_PIECES)
  ) u_front (
    .cmd           (cmd),
    .pieces_in_use (pieces_in_use),
    .q_stat        (q_stat),
    .push          (push),
    .job           (job_in)
  );

  pwmf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_out),
    .stat (q_stat)
  );

  pwmf_back #(
    .MAX_PIECES (MAX_PIECES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .job    (job_out),
    .q_stat (q_stat),
    .pop    (pop),
    .tx     (tx)
  );

  `PWMF_ASSERT(a_idle_after_reset, clk, $past(rst) |-> !tx.valid, "byte beat right after reset")
  `PWMF_ASSERT_RST(a_pop_nonempty, clk, rst, pop |-> !q_stat.empty, "pop from empty queue")
  `PWMF_ASSERT_RST(a_q_bound, clk, rst, q_stat.count <= 2'(pwmf_pkg::QDepth), "queue overfull")

endmodule

`default_nettype wire

[src/pwmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pwmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/pwmf_front.sv]
// Front end: accepts commands and turns them into serializer jobs.
`default_nettype none

module pwmf_front #(
  parameter int MAX_PIECES = 256
) (
  pwmf_cmd_if.sink               cmd,
  input  wire logic [8:0]        pieces_in_use,
  input  pwmf_pkg::q_stat_t      q_stat,
  output logic                   push,
  output pwmf_pkg::job_t         job
);

  logic [31:0] prefix;
  logic [7:0]  id;
  logic [31:0] wa;
  logic [31:0] wb;
  logic [31:0] wc;
  logic        keep;
  logic [8:0]  n_sat;
  logic [9:0]  n_up;
  logic [pwmf_pkg::RowW-1:0] nrows;
  logic [7:0]  last_mask;

  assign cmd.ready = !q_stat.full;

  // bitmap geometry for the bitfield message
  always_comb begin
    n_sat = (pieces_in_use > 9'(MAX_PIECES)) ? 9'(MAX_PIECES) : pieces_in_use;
    n_up  = {1'b0, n_sat} + 10'd7;
    nrows = pwmf_pkg::RowW'(n_up[9:3]);
    last_mask = (n_sat[2:0] == 3'd0) ? 8'hff : ~(8'hff >> n_sat[2:0]);
  end

  always_comb begin
    prefix = '0;
    id     = '0;
    wa     = '0;
    wb     = '0;
    wc     = '0;
    keep   = 1'b1;
    job    = '0;
    job.kind = pwmf_pkg::JOB_MSG;
    unique case (pwmf_pkg::cmd_t'(cmd.command))
      pwmf_pkg::CMD_KEEPALIVE: begin
        prefix     = pwmf_pkg::LEN_KEEPALIVE;
        job.nbytes = pwmf_pkg::NB_KEEPALIVE;
      end
      pwmf_pkg::CMD_CHOKE: begin
        prefix     = pwmf_pkg::LEN_STATUS;
        id         = pwmf_pkg::ID_CHOKE;
        job.nbytes = pwmf_pkg::NB_STATUS;
      end
      pwmf_pkg::CMD_UNCHOKE: begin
        prefix     = pwmf_pkg::LEN_STATUS;
        id         = pwmf_pkg::ID_UNCHOKE;
        job.nbytes = pwmf_pkg::NB_STATUS;
      end
      pwmf_pkg::CMD_INTERESTED: begin
        prefix     = pwmf_pkg::LEN_STATUS;
        id         = pwmf_pkg::ID_INTERESTED;
        job.nbytes = pwmf_pkg::NB_STATUS;
      end
      pwmf_pkg::CMD_NOT_INTERESTED: begin
        prefix     = pwmf_pkg::LEN_STATUS;
        id         = pwmf_pkg::ID_NOT_INTERESTED;
        job.nbytes = pwmf_pkg::NB_STATUS;
      end
      pwmf_pkg::CMD_HAVE: begin
        prefix     = pwmf_pkg::LEN_HAVE;
        id         = pwmf_pkg::ID_HAVE;
        wa         = cmd.piece_index;
        job.nbytes = pwmf_pkg::NB_HAVE;
      end
      pwmf_pkg::CMD_BITFIELD: begin
        job.kind      = pwmf_pkg::JOB_BITFIELD;
        prefix        = 32'(nrows) + pwmf_pkg::LEN_STATUS;
        id            = pwmf_pkg::ID_BITFIELD;
        job.nbytes    = pwmf_pkg::NB_BF_HEAD;
        job.nrows     = nrows;
        job.last_mask = last_mask;
      end
      pwmf_pkg::CMD_REQUEST: begin
        prefix     = pwmf_pkg::LEN_REQUEST;
        id         = pwmf_pkg::ID_REQUEST;
        wa         = cmd.piece_index;
        wb         = cmd.block_begin;
        wc         = cmd.block_length;
        job.nbytes = pwmf_pkg::NB_REQUEST;
      end
      pwmf_pkg::CMD_CANCEL: begin
        prefix     = pwmf_pkg::LEN_REQUEST;
        id         = pwmf_pkg::ID_CANCEL;
        wa         = cmd.piece_index;
        wb         = cmd.block_begin;
        wc         = cmd.block_length;
        job.nbytes = pwmf_pkg::NB_REQUEST;
      end
      pwmf_pkg::CMD_PIECE: begin
        prefix     = pwmf_pkg::LEN_PIECE_BASE + cmd.block_length;
        id         = pwmf_pkg::ID_PIECE;
        wa         = cmd.piece_index;
        wb         = cmd.block_begin;
        job.nbytes = pwmf_pkg::NB_PIECE;
      end
      pwmf_pkg::CMD_PORT: begin
        prefix     = pwmf_pkg::LEN_PORT;
        id         = pwmf_pkg::ID_PORT;
        wa         = {cmd.listen_port, 16'h0000};
        job.nbytes = pwmf_pkg::NB_PORT;
      end
      pwmf_pkg::CMD_MARK: begin
        // out-of-range marks are dropped here
        job.kind    = pwmf_pkg::JOB_MARK;
        keep        = cmd.piece_index < 32'(MAX_PIECES);
        job.row     = cmd.piece_index[3 +: pwmf_pkg::RowW];
        job.bit_sel = cmd.piece_index[2:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    job.msg = {prefix, id, wa, wb, wc};
  end

  assign push = cmd.valid && cmd.ready && keep;

endmodule

`default_nettype wire

[src/pwmf_queue.sv]
// Two-entry job queue between front end and serializer.
`default_nettype none

module pwmf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  pwmf_pkg::job_t     din,
  input  wire logic          pop,
  output pwmf_pkg::job_t     dout,
  output pwmf_pkg::q_stat_t  stat
);

  pwmf_pkg::job_t slots [pwmf_pkg::QDepth];
  logic [pwmf_pkg::QPtrW-1:0] wr_ptr;
  logic [pwmf_pkg::QPtrW-1:0] rd_ptr;
  logic [pwmf_pkg::QCntW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  assign dout       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == pwmf_pkg::QCntW'(pwmf_pkg::QDepth));

endmodule

`default_nettype wire

[src/pwmf_back.sv]
// Back end: serializes jobs into bytes and keeps the piece bitmap.
`default_nettype none

module pwmf_back #(
  parameter int MAX_PIECES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pwmf_pkg::job_t     job,
  input  pwmf_pkg::q_stat_t  q_stat,
  output logic               pop,
  pwmf_byte_if.source        tx
);

  localparam int Rows = (MAX_PIECES + 7) / 8;
  localparam int AW   = (Rows > 1) ? $clog2(Rows) : 1;

  pwmf_pkg::back_state_t state, state_next;

  logic [pwmf_pkg::MsgW-1:0] msg, msg_next;
  logic [pwmf_pkg::CntW-1:0] left, left_next;
  logic [pwmf_pkg::RowW-1:0] row, row_next;
  pwmf_pkg::job_kind_t       kind;
  logic [pwmf_pkg::RowW-1:0] nrows;
  logic [7:0]                last_mask;
  logic [2:0]                bit_sel;
  logic [Rows-1:0]           row_valid;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  logic       can_put;
  logic       put;
  logic [7:0] put_byte;
  logic       put_last;
  logic       ram_re;
  logic       ram_we;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;
  logic [7:0] row_data;
  logic       row_last;
  logic [AW-1:0] row_a;

  assign row_a    = row[AW-1:0];
  // unwritten rows read as zero
  assign row_data = row_valid[row_a] ? ram_rdata : 8'h00;
  assign row_last = (row == nrows - 1'b1);
  assign can_put  = !out_valid || tx.ready;

  pwmf_ram #(
    .WIDTH (8),
    .DEPTH (Rows)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_a),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (row_a),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwmf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    msg_next   = msg;
    left_next  = left;
    row_next   = row;
    pop        = 1'b0;
    put        = 1'b0;
    put_byte   = '0;
    put_last   = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = row_data | (8'h80 >> bit_sel);
    unique case (state)
      pwmf_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          msg_next  = job.msg;
          left_next = job.nbytes;
          row_next  = (job.kind == pwmf_pkg::JOB_MARK) ? job.row : '0;
          unique case (job.kind)
            pwmf_pkg::JOB_MSG,
            pwmf_pkg::JOB_BITFIELD: state_next = pwmf_pkg::BK_HEAD;
            pwmf_pkg::JOB_MARK:     state_next = pwmf_pkg::BK_MARK_RD;
            default:                state_next = pwmf_pkg::BK_IDLE;
          endcase
        end
      end
      pwmf_pkg::BK_HEAD: begin
        if (can_put) begin
          put       = 1'b1;
          put_byte  = msg[pwmf_pkg::MsgW-1 -: 8];
          msg_next  = msg << 8;
          left_next = left - 1'b1;
          if (left == pwmf_pkg::CntW'(1)) begin
            if (kind == pwmf_pkg::JOB_BITFIELD && nrows != '0) begin
              state_next = pwmf_pkg::BK_MAP_RD;
            end else begin
              put_last   = 1'b1;
              state_next = pwmf_pkg::BK_IDLE;
            end
          end
        end
      end
      pwmf_pkg::BK_MAP_RD: begin
        ram_re     = 1'b1;
        state_next = pwmf_pkg::BK_MAP_PUT;
      end
      pwmf_pkg::BK_MAP_PUT: begin
        if (can_put) begin
          put      = 1'b1;
          put_byte = row_data & (row_last ? last_mask : 8'hff);
          put_last = row_last;
          if (row_last) begin
            state_next = pwmf_pkg::BK_IDLE;
          end else begin
            row_next   = row + 1'b1;
            state_next = pwmf_pkg::BK_MAP_RD;
          end
        end
      end
      pwmf_pkg::BK_MARK_RD: begin
        ram_re     = 1'b1;
        state_next = pwmf_pkg::BK_MARK_WR;
      end
      pwmf_pkg::BK_MARK_WR: begin
        ram_we     = 1'b1;
        state_next = pwmf_pkg::BK_IDLE;
      end
      default: begin
        state_next = pwmf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    msg  <= msg_next;
    left <= left_next;
    row  <= row_next;
    if (pop) begin
      kind      <= job.kind;
      nrows     <= job.nrows;
      last_mask <= job.last_mask;
      bit_sel   <= job.bit_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[row_a] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_byte <= put_byte;
      out_last <= put_last;
    end
  end

  assign tx.valid     = out_valid;
  assign tx.out_byte  = out_byte;
  assign tx.last_byte = out_last;

endmodule

`default_nettype wire
